### rtl/dlc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the door lock controller.
// Used by dlc_debounce, dlc_core and door_lock_controller_unit; no dependencies.
package dlc_pkg;

   // Field widths
   localparam int unsigned UnlockWidth = 16;
   localparam int unsigned HoldWidth   = 7;
   localparam int unsigned BeatWidth   = 5;
   localparam int unsigned NumKeys     = 3;

   // Configuration register indexes
   localparam logic [2:0] CSR_LONG_UNLOCK  = 3'd0;
   localparam logic [2:0] CSR_SHORT_UNLOCK = 3'd1;
   localparam logic [2:0] CSR_MIN_PRESS    = 3'd2;
   localparam logic [2:0] CSR_PRESS_MAX    = 3'd3;
   localparam logic [2:0] CSR_BUZZ_ON      = 3'd4;
   localparam logic [2:0] CSR_BUZZ_LAST    = 3'd5;

   // Key slots in the debounce array
   localparam int unsigned KeyLock  = 0;
   localparam int unsigned KeyOuter = 1;
   localparam int unsigned KeyInner = 2;

   // Lock levels; the fourth code is never reached and behaves as deadlocked
   typedef logic [1:0] lock_level_type;
   localparam lock_level_type LVL_OPEN   = 2'd0;
   localparam lock_level_type LVL_LOCKED = 2'd1;
   localparam lock_level_type LVL_DEAD   = 2'd2;

   // Configuration register set
   typedef struct packed {
      logic [UnlockWidth-1:0] long_unlock_ticks;
      logic [UnlockWidth-1:0] short_unlock_ticks;
      logic [HoldWidth-1:0]   min_press_ticks;
      logic [HoldWidth-1:0]   press_count_max;
      logic [BeatWidth-1:0]   buzz_on_passes;
      logic [BeatWidth-1:0]   buzz_last_count;
   } cfg_type;

   // One input item
   typedef struct packed {
      logic mains_ok;
      logic inner_unlock_key;
      logic outer_unlock_key;
      logic lock_key;
      logic tick;
   } pins_type;

   // Output latch, one result item
   typedef struct packed {
      logic buzzer;
      logic unlocked_led;
      logic locked_led;
      logic relay_open;
   } drive_type;

endpackage

### rtl/dlc_debounce.sv
`timescale 1ns / 1ps
// Release-triggered debouncer for one key: next hold count and click flag.
// Depends on dlc_pkg.
module dlc_debounce (
   input  logic                          pressed,
   input  logic [dlc_pkg::HoldWidth-1:0] count,
   input  logic [dlc_pkg::HoldWidth-1:0] count_max,
   input  logic [dlc_pkg::HoldWidth-1:0] min_press,
   output logic [dlc_pkg::HoldWidth-1:0] count_next,
   output logic                          click
);

   logic [dlc_pkg::HoldWidth:0] count_inc;

   // While held, count up and saturate at the maximum; on release, check the hold time.
   always_comb begin
      count_inc = {1'b0, count} + 1'b1;
      if (pressed) begin
         click = 1'b0;
         if (count_inc >= {1'b0, count_max}) begin
            count_next = count_max;
         end else begin
            count_next = count_inc[dlc_pkg::HoldWidth-1:0];
         end
      end else begin
         click      = (count >= min_press);
         count_next = '0;
      end
   end

endmodule

### rtl/dlc_core.sv
`timescale 1ns / 1ps
// Controller state and the per-item update: beat generator, unlock countdown,
// lock level, mains handling and key clicks. Depends on dlc_pkg, dlc_debounce.
module dlc_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  dlc_pkg::pins_type  pins,
   input  dlc_pkg::cfg_type   cfg,
   output dlc_pkg::drive_type drive_next
);

   logic [dlc_pkg::UnlockWidth-1:0] unlock_remaining_ff, unlock_remaining_in;
   dlc_pkg::lock_level_type         lock_level_ff, lock_level_in;
   logic                            emergency_seen_ff, emergency_seen_in;
   logic                            led_only_unlock_ff, led_only_unlock_in;
   logic [dlc_pkg::BeatWidth-1:0]   beat_counter_ff, beat_counter_in;
   logic [dlc_pkg::HoldWidth-1:0]   hold_count_ff [dlc_pkg::NumKeys];
   logic [dlc_pkg::HoldWidth-1:0]   hold_count_in [dlc_pkg::NumKeys];
   dlc_pkg::drive_type              drive_ff;
   logic [dlc_pkg::NumKeys-1:0]     key_level;
   logic [dlc_pkg::NumKeys-1:0]     click;
   logic [dlc_pkg::BeatWidth:0]     beat_inc;

   assign key_level[dlc_pkg::KeyLock]  = pins.lock_key;
   assign key_level[dlc_pkg::KeyOuter] = pins.outer_unlock_key;
   assign key_level[dlc_pkg::KeyInner] = pins.inner_unlock_key;

   // One debouncer per key; its result is used only on tick passes.
   for (genvar k = 0; k < dlc_pkg::NumKeys; k++) begin : g_key
      dlc_debounce u_debounce (
         .pressed    (key_level[k]),
         .count      (hold_count_ff[k]),
         .count_max  (cfg.press_count_max),
         .min_press  (cfg.min_press_ticks),
         .count_next (hold_count_in[k]),
         .click      (click[k])
      );
   end

   // Next state in the order the pass handles it: beat, countdown, mains, keys.
   always_comb begin
      beat_inc            = {1'b0, beat_counter_ff} + 1'b1;
      unlock_remaining_in = unlock_remaining_ff;
      lock_level_in       = lock_level_ff;
      emergency_seen_in   = emergency_seen_ff;
      led_only_unlock_in  = led_only_unlock_ff;
      beat_counter_in     = beat_counter_ff;
      drive_next          = drive_ff;

      // Buzzer beat runs on every pass without mains.
      if (!pins.mains_ok) begin
         drive_next.buzzer = (beat_counter_ff < cfg.buzz_on_passes);
         if (beat_inc > {1'b0, cfg.buzz_last_count} || beat_inc[dlc_pkg::BeatWidth]) begin
            beat_counter_in = '0;
         end else begin
            beat_counter_in = beat_inc[dlc_pkg::BeatWidth-1:0];
         end
      end

      if (pins.tick) begin
         // Unlock countdown and indicators.
         if (unlock_remaining_ff != '0) begin
            unlock_remaining_in     = unlock_remaining_ff - 1'b1;
            drive_next.locked_led   = 1'b0;
            drive_next.unlocked_led = 1'b0;
            if (!led_only_unlock_ff) begin
               drive_next.relay_open = 1'b1;
            end
         end else begin
            led_only_unlock_in    = 1'b0;
            drive_next.relay_open = 1'b0;
            if (lock_level_ff == dlc_pkg::LVL_OPEN || emergency_seen_ff) begin
               drive_next.unlocked_led = 1'b1;
               drive_next.locked_led   = 1'b0;
            end else begin
               drive_next.locked_led   = 1'b1;
               drive_next.unlocked_led = 1'b0;
            end
         end

         // Mains handling: a return from an emergency grants an LED-only unlock.
         if (pins.mains_ok) begin
            drive_next.buzzer = 1'b0;
            if (emergency_seen_ff) begin
               unlock_remaining_in = cfg.long_unlock_ticks;
               lock_level_in       = dlc_pkg::LVL_OPEN;
               emergency_seen_in   = 1'b0;
               led_only_unlock_in  = 1'b1;
            end
         end else begin
            emergency_seen_in = 1'b1;
         end

         // Lock key click.
         if (click[dlc_pkg::KeyLock]) begin
            unlock_remaining_in     = '0;
            drive_next.locked_led   = 1'b1;
            drive_next.unlocked_led = 1'b0;
            if (lock_level_in == dlc_pkg::LVL_OPEN) begin
               lock_level_in = dlc_pkg::LVL_LOCKED;
            end else if (!pins.mains_ok) begin
               lock_level_in = dlc_pkg::LVL_DEAD;
            end
         end

         // Outer unlock key click.
         if (click[dlc_pkg::KeyOuter]) begin
            if (pins.mains_ok) begin
               if (lock_level_in == dlc_pkg::LVL_OPEN) begin
                  unlock_remaining_in = cfg.long_unlock_ticks;
                  led_only_unlock_in  = 1'b0;
               end
            end else if (lock_level_in < dlc_pkg::LVL_DEAD) begin
               unlock_remaining_in = cfg.long_unlock_ticks;
               lock_level_in       = dlc_pkg::LVL_OPEN;
               led_only_unlock_in  = 1'b0;
            end
         end

         // Inner unlock key click.
         if (click[dlc_pkg::KeyInner]) begin
            unlock_remaining_in     = cfg.short_unlock_ticks;
            drive_next.unlocked_led = 1'b1;
            drive_next.locked_led   = 1'b0;
            lock_level_in           = dlc_pkg::LVL_OPEN;
            led_only_unlock_in      = 1'b0;
         end
      end
   end

   // State registers, updated once per processed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         unlock_remaining_ff <= '0;
         lock_level_ff       <= dlc_pkg::LVL_OPEN;
         emergency_seen_ff   <= 1'b0;
         led_only_unlock_ff  <= 1'b0;
         beat_counter_ff     <= '0;
         drive_ff            <= '{buzzer: 1'b0, unlocked_led: 1'b1,
                                  locked_led: 1'b0, relay_open: 1'b0};
         for (int k = 0; k < dlc_pkg::NumKeys; k++) begin
            hold_count_ff[k] <= '0;
         end
      end else if (advance) begin
         unlock_remaining_ff <= unlock_remaining_in;
         lock_level_ff       <= lock_level_in;
         emergency_seen_ff   <= emergency_seen_in;
         led_only_unlock_ff  <= led_only_unlock_in;
         beat_counter_ff     <= beat_counter_in;
         drive_ff            <= drive_next;
         if (pins.tick) begin
            for (int k = 0; k < dlc_pkg::NumKeys; k++) begin
               hold_count_ff[k] <= hold_count_in[k];
            end
         end
      end
   end

endmodule

### rtl/door_lock_controller_unit.sv
`timescale 1ns / 1ps
// Door lock controller top level: stream ports, configuration registers,
// input and result registers. Depends on dlc_pkg and dlc_core.

// Each request item is one polling pass of the door lock: a 10 ms tick flag,
// three active-high key levels and the mains-ok line. Every item yields exactly
// one response item with the relay, locked LED, unlocked LED and buzzer drives.
// An item goes through an input register, the update logic and a result
// register; a new item is taken every cycle while the response side takes its
// items, and throughput is set only by the response side taking them. The
// configuration port is always ready, and registers should be written only
// while no item is in flight.
module door_lock_controller_unit (
   input  logic        clock,
   input  logic        reset,
   // Request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] tick, [1] lock_key, [2] outer_unlock_key,
                                    // [3] inner_unlock_key, [4] mains_ok, [7:5] zero
   // Response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] relay_open, [1] locked_led, [2] unlocked_led,
                                    // [3] buzzer, [7:4] zero
   // Configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   dlc_pkg::cfg_type   cfg_ff;
   dlc_pkg::pins_type  pins_ff;
   logic               in_valid_ff;
   logic               rsp_valid_ff;
   dlc_pkg::drive_type rsp_data_ff;
   dlc_pkg::drive_type drive_next;
   logic               advance;

   // Configuration registers; an unknown index is ignored.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_unlock_ticks  <= 16'd300;
         cfg_ff.short_unlock_ticks <= 16'd100;
         cfg_ff.min_press_ticks    <= 7'd4;
         cfg_ff.press_count_max    <= 7'd100;
         cfg_ff.buzz_on_passes     <= 5'd11;
         cfg_ff.buzz_last_count    <= 5'd22;
      end else if (csr_valid) begin
         unique case (csr_index)
            dlc_pkg::CSR_LONG_UNLOCK:  cfg_ff.long_unlock_ticks  <= csr_wdata;
            dlc_pkg::CSR_SHORT_UNLOCK: cfg_ff.short_unlock_ticks <= csr_wdata;
            dlc_pkg::CSR_MIN_PRESS: begin
               cfg_ff.min_press_ticks <= csr_wdata[dlc_pkg::HoldWidth-1:0];
            end
            dlc_pkg::CSR_PRESS_MAX: begin
               cfg_ff.press_count_max <= csr_wdata[dlc_pkg::HoldWidth-1:0];
            end
            dlc_pkg::CSR_BUZZ_ON: begin
               cfg_ff.buzz_on_passes <= csr_wdata[dlc_pkg::BeatWidth-1:0];
            end
            dlc_pkg::CSR_BUZZ_LAST: begin
               cfg_ff.buzz_last_count <= csr_wdata[dlc_pkg::BeatWidth-1:0];
            end
            default: ;
         endcase
      end
   end

   // The held item is processed when the result register is free or being emptied.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         pins_ff <= req_tdata[4:0];
      end
   end

   dlc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .pins       (pins_ff),
      .cfg        (cfg_ff),
      .drive_next (drive_next)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= drive_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff};

endmodule

### tb/sv/door_lock_controller_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for door_lock_controller_unit: a queue-fed driver, a monitor
// with a cycle-free model of the lock logic, and random idling on both streams.
// Depends on dlc_pkg and the door_lock_controller_unit RTL.
module door_lock_controller_unit_test;

   // Test knobs
   localparam int unsigned IdlePct       = 32;
   localparam int unsigned RspHoldCycles = 80;
   localparam int unsigned QuietLimit    = 2000;
   localparam int unsigned ResetCycles   = 5;
   localparam int unsigned DrainCycles   = 8;
   localparam int unsigned GapPct        = 15;
   localparam int unsigned PhaseItems    = 150;

   // Register indexes with no register behind them
   localparam logic [2:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [2:0] CSR_UNUSED_HI = 3'd7;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index  = 3'd0;
   logic [15:0] csr_wdata  = 16'd0;

   door_lock_controller_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Stimulus and scoreboard storage
   dlc_pkg::pins_type  pins_to_send[$];
   dlc_pkg::drive_type drives_expected[$];
   int        queued_total = 0;
   int        taken_cnt    = 0;
   int        matched_cnt  = 0;
   int        fail_count   = 0;
   int        plan_min     = 4;
   logic      idle_enabled = 1'b1;
   logic      hold_ask     = 1'b0;
   logic      req_took     = 1'b0;

   // Model copy of the configuration and of the controller state
   dlc_pkg::cfg_type                cfg_live;
   logic [dlc_pkg::UnlockWidth-1:0] unlock_left;
   dlc_pkg::lock_level_type         door_level;
   logic                            mains_lost_seen;
   logic                            led_only;
   logic [dlc_pkg::HoldWidth-1:0]   hold_count [dlc_pkg::NumKeys];
   logic [dlc_pkg::BeatWidth-1:0]   beat_count;
   dlc_pkg::drive_type              drive_latch;

   function automatic void clear_model();
      cfg_live.long_unlock_ticks  = 16'd300;
      cfg_live.short_unlock_ticks = 16'd100;
      cfg_live.min_press_ticks    = 7'd4;
      cfg_live.press_count_max    = 7'd100;
      cfg_live.buzz_on_passes     = 5'd11;
      cfg_live.buzz_last_count    = 5'd22;
      unlock_left     = '0;
      door_level      = dlc_pkg::LVL_OPEN;
      mains_lost_seen = 1'b0;
      led_only        = 1'b0;
      for (int k = 0; k < dlc_pkg::NumKeys; k++) hold_count[k] = '0;
      beat_count  = '0;
      drive_latch = '{buzzer: 1'b0, unlocked_led: 1'b1, locked_led: 1'b0, relay_open: 1'b0};
   endfunction

   function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] val);
      case (idx)
         dlc_pkg::CSR_LONG_UNLOCK:  cfg_live.long_unlock_ticks  = val;
         dlc_pkg::CSR_SHORT_UNLOCK: cfg_live.short_unlock_ticks = val;
         dlc_pkg::CSR_MIN_PRESS:    cfg_live.min_press_ticks    = val[dlc_pkg::HoldWidth-1:0];
         dlc_pkg::CSR_PRESS_MAX:    cfg_live.press_count_max    = val[dlc_pkg::HoldWidth-1:0];
         dlc_pkg::CSR_BUZZ_ON:      cfg_live.buzz_on_passes     = val[dlc_pkg::BeatWidth-1:0];
         dlc_pkg::CSR_BUZZ_LAST:    cfg_live.buzz_last_count    = val[dlc_pkg::BeatWidth-1:0];
         default: ;
      endcase
   endfunction

   // Release-triggered debounce: a click is a release after enough held ticks.
   function automatic logic key_click(input int unsigned key, input logic pressed);
      logic [dlc_pkg::HoldWidth:0] bumped;
      logic                        click;
      click = 1'b0;
      if (pressed) begin
         bumped = hold_count[key] + 1'b1;
         if (bumped >= {1'b0, cfg_live.press_count_max})
            bumped = {1'b0, cfg_live.press_count_max};
         hold_count[key] = bumped[dlc_pkg::HoldWidth-1:0];
      end else begin
         click = hold_count[key] >= cfg_live.min_press_ticks;
         hold_count[key] = '0;
      end
      return click;
   endfunction

   // One polling pass of the lock: returns the output latch after the pass.
   function automatic dlc_pkg::drive_type poll_door(input dlc_pkg::pins_type p);
      logic [dlc_pkg::BeatWidth:0] beat_next;
      // The buzzer beat advances on every pass without mains.
      if (!p.mains_ok) begin
         drive_latch.buzzer = beat_count < cfg_live.buzz_on_passes;
         beat_next = beat_count + 1'b1;
         if (beat_next > {1'b0, cfg_live.buzz_last_count} || beat_next[dlc_pkg::BeatWidth])
            beat_next = '0;
         beat_count = beat_next[dlc_pkg::BeatWidth-1:0];
      end
      if (p.tick) begin
         // Unlock countdown and indicator update.
         if (unlock_left != 0) begin
            unlock_left = unlock_left - 1'b1;
            drive_latch.locked_led   = 1'b0;
            drive_latch.unlocked_led = 1'b0;
            if (!led_only) drive_latch.relay_open = 1'b1;
         end else begin
            led_only = 1'b0;
            drive_latch.relay_open = 1'b0;
            if (door_level == dlc_pkg::LVL_OPEN || mains_lost_seen) begin
               drive_latch.unlocked_led = 1'b1;
               drive_latch.locked_led   = 1'b0;
            end else begin
               drive_latch.locked_led   = 1'b1;
               drive_latch.unlocked_led = 1'b0;
            end
         end
         // Mains handling: its return grants an LED-only unlock.
         if (p.mains_ok) begin
            drive_latch.buzzer = 1'b0;
            if (mains_lost_seen) begin
               unlock_left     = cfg_live.long_unlock_ticks;
               door_level      = dlc_pkg::LVL_OPEN;
               mains_lost_seen = 1'b0;
               led_only        = 1'b1;
            end
         end else begin
            mains_lost_seen = 1'b1;
         end
         if (key_click(dlc_pkg::KeyLock, p.lock_key)) begin
            unlock_left = '0;
            drive_latch.locked_led   = 1'b1;
            drive_latch.unlocked_led = 1'b0;
            if (door_level == dlc_pkg::LVL_OPEN) door_level = dlc_pkg::LVL_LOCKED;
            else if (!p.mains_ok) door_level = dlc_pkg::LVL_DEAD;
         end
         if (key_click(dlc_pkg::KeyOuter, p.outer_unlock_key)) begin
            if (p.mains_ok) begin
               if (door_level == dlc_pkg::LVL_OPEN) begin
                  unlock_left = cfg_live.long_unlock_ticks;
                  led_only    = 1'b0;
               end
            end else if (door_level < dlc_pkg::LVL_DEAD) begin
               unlock_left = cfg_live.long_unlock_ticks;
               door_level  = dlc_pkg::LVL_OPEN;
               led_only    = 1'b0;
            end
         end
         if (key_click(dlc_pkg::KeyInner, p.inner_unlock_key)) begin
            unlock_left = cfg_live.short_unlock_ticks;
            drive_latch.unlocked_led = 1'b1;
            drive_latch.locked_led   = 1'b0;
            door_level = dlc_pkg::LVL_OPEN;
            led_only   = 1'b0;
         end
      end
      return drive_latch;
   endfunction

   task automatic note_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $realtime, msg);
      fail_count++;
   endtask

   // Driver: offers the next pending item at the falling edge.
   always @(negedge clock) begin
      dlc_pkg::pins_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (pins_to_send.size() != 0 &&
             !(idle_enabled && $urandom_range(99) < IdlePct)) begin
            nxt = pins_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {3'b000, nxt};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure plus one long hold-off on request.
   int unsigned rsp_hold_left = 0;
   logic        hold_served   = 1'b0;
   always @(negedge clock) begin
      if (rsp_hold_left != 0) begin
         rsp_hold_left = rsp_hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_ask && !hold_served) begin
         hold_served   = 1'b1;
         rsp_hold_left = RspHoldCycles;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(idle_enabled && $urandom_range(99) < IdlePct);
      end
   end

   // Monitor: runs the model on accepted items and checks every result item.
   always @(posedge clock) begin
      dlc_pkg::drive_type got;
      dlc_pkg::drive_type want;
      if (reset) begin
         clear_model();
         req_took <= 1'b0;
      end else begin
         req_took <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (drives_expected.size() == 0) begin
               note_mismatch($sformatf("result %h with none expected", rsp_tdata));
            end else begin
               want = drives_expected.pop_front();
               got  = dlc_pkg::drive_type'(rsp_tdata[3:0]);
               if (got.relay_open !== want.relay_open)
                  note_mismatch($sformatf("item %0d relay_open %b, expected %b",
                                          matched_cnt, got.relay_open, want.relay_open));
               if (got.locked_led !== want.locked_led)
                  note_mismatch($sformatf("item %0d locked_led %b, expected %b",
                                          matched_cnt, got.locked_led, want.locked_led));
               if (got.unlocked_led !== want.unlocked_led)
                  note_mismatch($sformatf("item %0d unlocked_led %b, expected %b",
                                          matched_cnt, got.unlocked_led, want.unlocked_led));
               if (got.buzzer !== want.buzzer)
                  note_mismatch($sformatf("item %0d buzzer %b, expected %b",
                                          matched_cnt, got.buzzer, want.buzzer));
               if (rsp_tdata[7:4] !== 4'd0)
                  note_mismatch($sformatf("item %0d pad bits %b, expected zero",
                                          matched_cnt, rsp_tdata[7:4]));
               matched_cnt <= matched_cnt + 1;
            end
         end
         if (csr_valid && csr_ready) apply_reg(csr_index, csr_wdata);
         if (req_tvalid && req_tready) begin
            drives_expected.push_back(poll_door(dlc_pkg::pins_type'(req_tdata[4:0])));
            taken_cnt <= taken_cnt + 1;
         end
      end
   end

   // Watchdog on cycles with no handshake at all.
   int unsigned quiet_cycles = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= QuietLimit) begin
            $display("TEST FAILED");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   function automatic dlc_pkg::pins_type make_pins(input logic tick, input logic lk,
                                                   input logic ok, input logic ik,
                                                   input logic mains);
      dlc_pkg::pins_type p;
      p.tick             = tick;
      p.lock_key         = lk;
      p.outer_unlock_key = ok;
      p.inner_unlock_key = ik;
      p.mains_ok         = mains;
      return p;
   endfunction

   function automatic void queue_pass(input dlc_pkg::pins_type p);
      pins_to_send.push_back(p);
      queued_total++;
   endfunction

   // Holds one key for a number of ticks and then releases it on a tick.
   function automatic void queue_hold(input int unsigned key, input int unsigned held,
                                      input logic mains, input logic with_gaps);
      logic down;
      for (int unsigned i = 0; i <= held; i++) begin
         down = i < held;
         if (with_gaps && $urandom_range(99) < GapPct)
            queue_pass(make_pins(1'b0, down && key == dlc_pkg::KeyLock,
                                 down && key == dlc_pkg::KeyOuter,
                                 down && key == dlc_pkg::KeyInner, mains));
         queue_pass(make_pins(1'b1, down && key == dlc_pkg::KeyLock,
                              down && key == dlc_pkg::KeyOuter,
                              down && key == dlc_pkg::KeyInner, mains));
      end
   endfunction

   // Mostly well-formed key presses, with mains outages and raw noise mixed in.
   function automatic void queue_random_passes(input int count);
      int   start;
      int   pick;
      logic mains;
      start = queued_total;
      mains = 1'b1;
      while (queued_total - start < count) begin
         pick = $urandom_range(99);
         if (pick < 65)
            queue_hold($urandom_range(dlc_pkg::NumKeys - 1), $urandom_range(plan_min + 3),
                       mains, 1'b1);
         else if (pick < 80)
            mains = !mains;
         else
            queue_pass(dlc_pkg::pins_type'(5'($urandom_range(31))));
      end
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pins_to_send.size() != 0 || req_tvalid || matched_cnt != taken_cnt);
   endtask

   task automatic write_all(input logic [15:0] long_t, input logic [15:0] short_t,
                            input logic [15:0] min_t, input logic [15:0] max_t,
                            input logic [15:0] on_t, input logic [15:0] last_t);
      write_reg(dlc_pkg::CSR_LONG_UNLOCK, long_t);
      write_reg(dlc_pkg::CSR_SHORT_UNLOCK, short_t);
      write_reg(dlc_pkg::CSR_MIN_PRESS, min_t);
      write_reg(dlc_pkg::CSR_PRESS_MAX, max_t);
      write_reg(dlc_pkg::CSR_BUZZ_ON, on_t);
      write_reg(dlc_pkg::CSR_BUZZ_LAST, last_t);
      plan_min = int'(min_t[dlc_pkg::HoldWidth-1:0]);
   endtask

   initial begin
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed passes at the reset settings.
      queue_pass(make_pins(1'b0, 1'b0, 1'b0, 1'b0, 1'b1));   // no tick: latch as reset
      queue_pass(make_pins(1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
      queue_hold(dlc_pkg::KeyLock, 4, 1'b1, 1'b0);            // lock click
      queue_pass(make_pins(1'b1, 1'b0, 1'b0, 1'b0, 1'b1));   // locked LED
      queue_pass(make_pins(1'b0, 1'b1, 1'b1, 1'b1, 1'b0));   // outage, beat only
      queue_pass(make_pins(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));   // outage seen on a tick
      queue_pass(make_pins(1'b1, 1'b0, 1'b0, 1'b0, 1'b1));   // mains back: LED-only unlock
      queue_pass(make_pins(1'b1, 1'b0, 1'b0, 1'b0, 1'b1));   // relay keeps its value
      queue_hold(dlc_pkg::KeyInner, 4, 1'b1, 1'b0);           // short unlock
      queue_hold(dlc_pkg::KeyOuter, 4, 1'b1, 1'b0);           // long unlock
      queue_pass(make_pins(1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
      queue_pass(make_pins(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
      queue_random_passes(PhaseItems);
      wait_drained();

      // Small values; the result side stalls long enough to back up the input.
      write_all(16'd5, 16'd3, 16'd1, 16'd2, 16'd3, 16'd5);
      write_reg(CSR_UNUSED_LO, 16'hFFFF);
      @(posedge clock);
      queue_random_passes(PhaseItems);
      hold_ask = 1'b1;
      wait_drained();

      // All zero: every release is a click, counters stuck at zero, no buzz.
      write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      write_reg(CSR_UNUSED_HI, 16'h0001);
      @(posedge clock);
      idle_enabled = 1'b0;
      queue_random_passes(PhaseItems);
      wait_drained();
      idle_enabled = 1'b1;

      // Largest values; the minimum press is written with spare high bits set.
      write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd127, 16'd31, 16'd31);
      @(posedge clock);
      queue_random_passes(PhaseItems);
      wait_drained();

      // Random small settings.
      for (int n = 0; n < 3; n++) begin
         write_all(16'($urandom_range(40)), 16'($urandom_range(40)),
                   16'($urandom_range(8)), 16'($urandom_range(12)),
                   16'($urandom_range(31)), 16'($urandom_range(31)));
         @(posedge clock);
         queue_random_passes(PhaseItems);
         wait_drained();
      end

      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0 && drives_expected.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
